// ===== hdl/msc_pkg.sv =====
`timescale 1ns / 1ps
package msc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEC,
        ST_ROW,
        ST_PROD,
        ST_LEFT,
        ST_RIGHT,
        ST_RUNS,
        ST_SCAN,
        ST_DRAIN,
        ST_CLASS,
        ST_OUT
    } msc_state_t;

    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    localparam logic [1:0] CLASS_OCEAN = 2'd0;
    localparam logic [1:0] CLASS_LAND  = 2'd1;
    localparam logic [1:0] CLASS_COAST = 2'd2;

    localparam int LAT_W   = 16;
    localparam int LON_W   = 17;
    localparam int VIEW_W  = 12;
    localparam int OFS_W   = 8;
    localparam int MROW_W  = 11;
    localparam int MCOL_W  = 12;
    localparam int COUNT_W = 22;
    localparam int SEC_W   = 16;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = 40;

    localparam int LAT_OFFSET = 90 * 256;
    localparam int LON_OFFSET = 180 * 256;
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

    localparam logic [SEC_W-1:0] SEC_TABLE [0:90] = '{
        16'd256, 16'd256, 16'd256, 16'd256, 16'd257, 16'd257, 16'd257, 16'd258,
        16'd259, 16'd259, 16'd260, 16'd261, 16'd262, 16'd263, 16'd264, 16'd265,
        16'd266, 16'd268, 16'd269, 16'd271, 16'd272, 16'd274, 16'd276, 16'd278,
        16'd280, 16'd282, 16'd285, 16'd287, 16'd290, 16'd293, 16'd296, 16'd299,
        16'd302, 16'd305, 16'd309, 16'd313, 16'd316, 16'd321, 16'd325, 16'd329,
        16'd334, 16'd339, 16'd344, 16'd350, 16'd356, 16'd362, 16'd369, 16'd375,
        16'd383, 16'd390, 16'd398, 16'd407, 16'd416, 16'd425, 16'd436, 16'd446,
        16'd458, 16'd470, 16'd483, 16'd497, 16'd512, 16'd528, 16'd545, 16'd564,
        16'd584, 16'd606, 16'd629, 16'd655, 16'd683, 16'd714, 16'd748, 16'd786,
        16'd828, 16'd876, 16'd929, 16'd989, 16'd1058, 16'd1138, 16'd1231, 16'd1342,
        16'd1474, 16'd1636, 16'd1839, 16'd2101, 16'd2449, 16'd2937, 16'd3670,
        16'd4891, 16'd7335, 16'd14668, 16'd65535
    };

endpackage

// ===== hdl/mask_window_surface_classifier.sv =====
`timescale 1ns / 1ps
// land mask surface classifier
// s_ channel: one transfer per request, s_tuser selects a pixel write (0) or a
// classify request (1); s_tdata carries the pixel position and value or the
// view centre, view size and row offsets
// m_ channel: one transfer per classify request, class code on m_tuser,
// land and pixel counts on m_tdata; pixel writes give no transfer
// a pixel write is taken in the idle state and the block stays ready
// a classify request scans the box row by row, visiting the pixels of each
// row in one or two column runs: the mask has one read port and one pixel is
// read per cycle, and the box bounds go through one shared multiplier in five
// steps
// the result is valid in ST_OUT after ST_SCAN, ST_DRAIN and ST_CLASS, and
// with the receiver ready the block returns to ST_IDLE for the next request
// s_tready is low from the classify transfer until its result is taken, so
// a stalled receiver holds the block with the result steady on m_tdata
// reset clears the sequencer only; the mask keeps its contents and a pixel
// never written reads as undefined
module mask_window_surface_classifier #(
    parameter int MAP_COLS          = 2160,
    parameter int MAP_ROWS          = 1080,
    parameter int PIXELS_PER_DEGREE = 6,
    parameter int SECANT_LIMIT      = 200
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mask_row, mask_col, mask_is_land, latitude, longitude, view_size,
    // rows_above, rows_below
    input  logic [87:0] s_tdata,
    // req_type
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // land_count, pixel_count
    output logic [47:0] m_tdata,
    // surface_class
    output logic [1:0]  m_tuser
);
    import msc_pkg::*;

    localparam int DEPTH  = MAP_ROWS * MAP_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int COL_W  = $clog2(MAP_COLS);
    localparam int EDGE_W = COL_W + 2;
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int CMP_W  = CNT_W + 7;

    msc_state_t state_reg, state_next;

    logic signed [LAT_W-1:0]  lat_reg;
    logic signed [LON_W-1:0]  lon_reg;
    logic [VIEW_W-1:0]        view_reg;
    logic [OFS_W-1:0]         up_reg, down_reg;
    logic [SEC_W-1:0]         sec_reg;
    logic [ROW_W-1:0]         top_reg, bot_reg, row_reg;
    logic signed [31:0]       vprod_reg;
    logic signed [EDGE_W-1:0] left_reg, right_reg;
    logic [COL_W-1:0]         s0_reg, e0_reg, s1_reg, e1_reg, col_reg;
    logic                     v0_reg, v1_reg, run_reg, pend_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [CNT_W-1:0]         land_reg, cnt_reg;
    logic [1:0]               class_reg;
    logic [COUNT_W-1:0]       land_out_reg, cnt_out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic                 wr_en, rd_data;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic                 s_xfer, rd_en;

    logic [MROW_W-1:0] in_row;
    logic [MCOL_W-1:0] in_col;

    assign in_row = s_tdata[10:0];
    assign in_col = s_tdata[22:11];
    assign s_xfer = s_tvalid && s_tready;

    // pixel write path
    assign wr_en = s_xfer && (s_tuser[0] == REQ_WRITE)
                   && (32'(in_row) < 32'(MAP_ROWS)) && (32'(in_col) < 32'(MAP_COLS));
    assign wr_addr = ADDR_W'(32'(in_row) * 32'(MAP_COLS) + 32'(in_col));

    // secant lookup
    logic [LON_W-1:0] abs_lat;
    logic [7:0]       deg_raw, deg;
    logic [SEC_W-1:0] sec_raw, sec_val;

    always_comb begin
        abs_lat = lat_reg[LAT_W-1] ? (17'd0 - {lat_reg[LAT_W-1], lat_reg})
                                   : {1'b0, lat_reg};
        deg_raw = 8'((abs_lat + 17'd128) >> 8);
        deg     = (deg_raw > 8'd90) ? 8'(8'd180 - deg_raw) : deg_raw;
        sec_raw = SEC_TABLE[deg[6:0]];
        sec_val = (32'(sec_raw) > SECANT_LIMIT * 256) ? SEC_W'(SECANT_LIMIT * 256)
                                                      : sec_raw;
    end

    // row bounds
    logic signed [31:0] rnum, rtop, rbot;
    logic [ROW_W-1:0]   top_val, bot_val;

    always_comb begin
        rnum = 32'((MAP_ROWS - 1) * 256) + $signed({16'd0, up_reg, 8'd0}) - mul_p[31:0];
        rtop = (rnum + (rnum < 0 ? 32'sd255 : 32'sd0)) >>> 8;
        rbot = rtop - $signed({24'd0, down_reg});
        top_val = (rtop < 0) ? '0 : (rtop > MAP_ROWS - 1) ? ROW_W'(MAP_ROWS - 1)
                                                          : ROW_W'(rtop);
        bot_val = (rbot < 0) ? '0 : (rbot > MAP_ROWS - 1) ? ROW_W'(MAP_ROWS - 1)
                                                          : ROW_W'(rbot);
    end

    // column edges
    logic signed [31:0]       lon_base;
    logic signed [PROD_W-1:0] cq;
    logic signed [EDGE_W-1:0] edge_val;

    always_comb begin
        lon_base = (32'(lon_reg) + 32'(LON_OFFSET)) <<< 8;
        cq = (mul_p + (mul_p < 0 ? 40'sd65535 : 40'sd0)) >>> 16;
        if (cq < -PROD_W'(MAP_COLS)) begin
            edge_val = EDGE_W'(-MAP_COLS);
        end else if (cq > PROD_W'(2 * MAP_COLS - 1)) begin
            edge_val = EDGE_W'(2 * MAP_COLS - 1);
        end else begin
            edge_val = EDGE_W'(cq);
        end
    end

    // column runs of one row
    logic [COL_W-1:0] s0_val, e0_val, s1_val, e1_val;
    logic             v0_val, v1_val, l_neg, r_over;

    always_comb begin
        l_neg  = left_reg < 0;
        r_over = right_reg > EDGE_W'(MAP_COLS - 1);
        s0_val = '0;
        e0_val = COL_W'(MAP_COLS - 1);
        s1_val = '0;
        e1_val = COL_W'(MAP_COLS - 1);
        v0_val = 1'b1;
        v1_val = 1'b0;
        priority if (l_neg && r_over) begin
            v0_val = 1'b1;
        end else if (l_neg) begin
            e0_val = COL_W'(right_reg);
            v0_val = right_reg >= 0;
            s1_val = COL_W'(left_reg + EDGE_W'(MAP_COLS));
            v1_val = 1'b1;
        end else if (r_over) begin
            s0_val = COL_W'(left_reg);
            v0_val = left_reg <= EDGE_W'(MAP_COLS - 1);
            e1_val = COL_W'(right_reg - EDGE_W'(MAP_COLS));
            v1_val = 1'b1;
        end else begin
            s0_val = COL_W'(left_reg);
            e0_val = COL_W'(right_reg);
        end
    end

    // scan cursor
    logic             cur_v, run_end, scan_last;
    logic [COL_W-1:0] cur_e;

    always_comb begin
        cur_v     = run_reg ? v1_reg : v0_reg;
        cur_e     = run_reg ? e1_reg : e0_reg;
        run_end   = !cur_v || (col_reg == cur_e);
        scan_last = run_end && run_reg && (row_reg == top_reg);
    end

    assign rd_addr = base_reg + ADDR_W'(col_reg);

    // classification
    logic [CMP_W-1:0] land_x100, cnt_x99, cnt_x1;
    logic [1:0]       class_val;

    always_comb begin
        land_x100 = CMP_W'(land_reg) * CMP_W'(100);
        cnt_x99   = CMP_W'(cnt_reg) * CMP_W'(99);
        cnt_x1    = CMP_W'(cnt_reg);
        priority if (land_x100 >= cnt_x99) begin
            class_val = CLASS_LAND;
        end else if (land_x100 <= cnt_x1) begin
            class_val = CLASS_OCEAN;
        end else begin
            class_val = CLASS_COAST;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_tuser[0] == REQ_CLASSIFY) begin
                    state_next = ST_SEC;
                end
            end
            ST_SEC:   state_next = ST_ROW;
            ST_ROW:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_LEFT;
            ST_LEFT:  state_next = ST_RIGHT;
            ST_RIGHT: state_next = ST_RUNS;
            ST_RUNS:  state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_CLASS;
            ST_CLASS: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and shared multiplier operands
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        rd_en    = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SEC: begin
                mul_a = 32'(lat_reg) + 32'(LAT_OFFSET);
                mul_b = MUL_B_W'(PIXELS_PER_DEGREE);
            end
            ST_ROW: begin
                mul_a = 32'(view_reg);
                mul_b = MUL_B_W'(sec_reg);
            end
            ST_PROD: begin
                mul_a = lon_base - mul_p[31:0];
                mul_b = MUL_B_W'(PIXELS_PER_DEGREE);
            end
            ST_LEFT: begin
                mul_a = lon_base + vprod_reg;
                mul_b = MUL_B_W'(PIXELS_PER_DEGREE);
            end
            ST_RIGHT: begin
                mul_a = 32'(bot_reg);
                mul_b = MUL_B_W'(MAP_COLS);
            end
            ST_SCAN:  rd_en = cur_v;
            ST_OUT:   m_tvalid = 1'b1;
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_xfer) begin
            lat_reg  <= s_tdata[39:24];
            lon_reg  <= s_tdata[56:40];
            view_reg <= s_tdata[68:57];
            up_reg   <= s_tdata[76:69];
            down_reg <= s_tdata[84:77];
        end
        if (state_reg == ST_SEC) begin
            sec_reg  <= sec_val;
            land_reg <= '0;
            cnt_reg  <= '0;
        end
        if (state_reg == ST_ROW) begin
            top_reg <= top_val;
            bot_reg <= bot_val;
        end
        if (state_reg == ST_PROD) begin
            vprod_reg <= mul_p[31:0];
        end
        if (state_reg == ST_LEFT) begin
            left_reg <= edge_val;
        end
        if (state_reg == ST_RIGHT) begin
            right_reg <= edge_val;
        end
        if (state_reg == ST_RUNS) begin
            s0_reg   <= s0_val;
            e0_reg   <= e0_val;
            s1_reg   <= s1_val;
            e1_reg   <= e1_val;
            v0_reg   <= v0_val;
            v1_reg   <= v1_val;
            row_reg  <= bot_reg;
            base_reg <= ADDR_W'(mul_p);
            run_reg  <= 1'b0;
            col_reg  <= s0_val;
        end
        if (state_reg == ST_SCAN) begin
            if (!run_end) begin
                col_reg <= col_reg + 1'b1;
            end else if (!run_reg) begin
                run_reg <= 1'b1;
                col_reg <= s1_reg;
            end else begin
                run_reg  <= 1'b0;
                col_reg  <= s0_reg;
                row_reg  <= row_reg + 1'b1;
                base_reg <= base_reg + ADDR_W'(MAP_COLS);
            end
        end
        if (pend_reg) begin
            cnt_reg  <= cnt_reg + 1'b1;
            land_reg <= land_reg + CNT_W'(rd_data);
        end
        if (state_reg == ST_CLASS) begin
            class_reg    <= class_val;
            land_out_reg <= (32'(land_reg) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                        : COUNT_W'(land_reg);
            cnt_out_reg  <= (32'(cnt_reg) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                       : COUNT_W'(cnt_reg);
        end
    end

    assign m_tdata = {4'd0, cnt_out_reg, land_out_reg};
    assign m_tuser = class_reg;

    msc_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_p)
    );

    msc_mask #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mask (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (s_tdata[23]),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

endmodule

// ===== hdl/msc_mul.sv =====
`timescale 1ns / 1ps
module msc_mul (
    input  logic                                  aclk,
    input  logic signed [msc_pkg::MUL_A_W-1:0]    op_a,
    input  logic signed [msc_pkg::MUL_B_W-1:0]    op_b,
    output logic signed [msc_pkg::PROD_W-1:0]     prod_reg
);
    import msc_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;

    assign prod_full = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[PROD_W-1:0];
    end

endmodule

// ===== hdl/msc_mask.sv =====
`timescale 1ns / 1ps
module msc_mask #(
    parameter int DEPTH  = 2332800,
    parameter int ADDR_W = 22
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data_reg
);
    import msc_pkg::*;

    logic mem_q [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_q[rd_addr];
    end

endmodule

// ===== hdl/msc_checker.sv =====
`timescale 1ns / 1ps
module msc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import msc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:0] <= m_tdata[43:22]) && (m_tdata[43:22] != 22'd0))
        else $error("land count above pixel count or empty box");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[21:0] == m_tdata[43:22]) |-> m_tuser == CLASS_LAND)
        else $error("all-land box not classed as land");

endmodule

bind mask_window_surface_classifier msc_checker u_msc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
